// ----- design/dsak_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dsak_pkg;

	localparam int TIME_BITS     = 32;
	localparam int ATTEMPT_BITS  = 8;
	localparam int NUM_LEVELS    = 2;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [ATTEMPT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_LOCKED   = 2'd0,
		ST_SEEDED   = 2'd1,
		ST_UNLOCKED = 2'd2
	} lvl_state_t;

	typedef enum logic [2:0] {
		RC_NONE        = 3'd0,
		RC_LENGTH      = 3'd1,
		RC_UNSUPPORTED = 3'd2,
		RC_CONDITIONS  = 3'd3,
		RC_DELAY       = 3'd4,
		RC_SEQUENCE    = 3'd5,
		RC_BAD_KEY     = 3'd6,
		RC_ATTEMPTS    = 3'd7
	} rej_code_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_L1_LIMIT = 3'd0,
		CFG_L2_LIMIT = 3'd1,
		CFG_L1_DELAY = 3'd2,
		CFG_L2_DELAY = 3'd3,
		CFG_L1_MASK  = 3'd4,
		CFG_L2_MASK  = 3'd5
	} cfg_idx_t;

	localparam logic [7:0] SF_L1_SEED = 8'd1;
	localparam logic [7:0] SF_L1_KEY  = 8'd2;
	localparam logic [7:0] SF_L2_SEED = 8'd3;
	localparam logic [7:0] SF_L2_KEY  = 8'd4;

	localparam logic [7:0] SESS_PROG = 8'd2;
	localparam logic [7:0] SESS_EXT  = 8'd3;

	localparam logic [2:0] MASK_DEFAULT = 3'b001;
	localparam logic [2:0] MASK_PROG    = 3'b010;
	localparam logic [2:0] MASK_EXT     = 3'b100;

	localparam logic [7:0] REQ_LEN_MIN  = 8'd2;
	localparam logic [7:0] REQ_LEN_SEED = 8'd2;
	localparam logic [7:0] REQ_LEN_KEY1 = 8'd6;
	localparam logic [7:0] REQ_LEN_KEY2 = 8'd10;

	localparam logic [3:0] RSP_LEN_KEY   = 4'd1;
	localparam logic [3:0] RSP_LEN_SEED1 = 4'd5;
	localparam logic [3:0] RSP_LEN_SEED2 = 4'd9;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_L1   = 2'd1;
	localparam logic [1:0] ACT_L2   = 2'd2;

	localparam logic [31:0] SEED1_XOR    = 32'hDEADBEEF;
	localparam logic [31:0] KEY1_XOR     = 32'h12345678;
	localparam logic [31:0] SEED2_HI_XOR = 32'hCAFEBABE;
	localparam logic [31:0] SEED2_LO_XOR = 32'hFEEDFACE;
	localparam logic [63:0] KEY2_XOR     = 64'h123456789ABCDEF0;

	localparam logic [7:0]  RST_LIMIT = 8'd3;
	localparam logic [31:0] RST_DELAY = 32'd10000;
	localparam logic [2:0]  RST_MASK1 = 3'd6;
	localparam logic [2:0]  RST_MASK2 = 3'd2;

	typedef struct packed {
		logic        op;
		logic [7:0]  sub_fn;
		logic [7:0]  request_length;
		logic [63:0] key_value;
		logic [7:0]  session_id;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic        accepted;
		rej_code_t   reject_code;
		logic [7:0]  echo_sub_fn;
		logic [3:0]  response_length;
		logic [63:0] seed_out;
		logic [1:0]  active_level;
	} rsp_t;

	typedef struct packed {
		logic [NUM_LEVELS-1:0][7:0]  limit;
		logic [NUM_LEVELS-1:0][31:0] delay;
		logic [NUM_LEVELS-1:0][2:0]  mask;
	} cfg_t;

	typedef struct packed {
		lvl_state_t              status;
		logic [ATTEMPT_BITS-1:0] fcount;
		logic [TIME_BITS-1:0]    lstart;
		logic [63:0]             seed;
	} lvl_t;

	typedef struct packed {
		logic clr;
		logic we;
		logic idx;
		lvl_t lvl;
	} upd_t;

endpackage
`default_nettype wire

// ----- design/dsak_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface dsak_req_if;
	import dsak_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport src (output valid, output data, input ready);
	modport snk (input valid, input data, output ready);
endinterface

interface dsak_rsp_if;
	import dsak_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport src (output valid, output data, input ready);
	modport snk (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/diag_security_access_seed_key_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake         Payload
// req       in   valid/ready       op, sub_fn, request_length, key_value,
//                                  session_id, now_ms
// rsp       out  valid/ready       accepted, reject_code, echo_sub_fn,
//                                  response_length, seed_out, active_level
// cfg       in   cfg_we            cfg_idx, cfg_wdata
//
// One item per cycle sustained while rsp.ready stays high; an accepted item is
// held in the input register, and its result is then loaded into the result register.
// The input register feeds one pass of decision logic that updates the
// per-level state and loads the result register in the same cycle.
// Reset clears all level state and loads register defaults.
// A stalled result holds the input register; req.ready drops only when both
// stages are full and rsp.ready is low.
module diag_security_access_seed_key_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	dsak_req_if.snk                                 req,
	dsak_rsp_if.src                                 rsp,
	input  wire logic                               cfg_we,
	input  wire logic [dsak_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  wire logic [dsak_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import dsak_pkg::*;

	req_t                  req_s1;
	logic                  vld_s1;
	rsp_t                  rsp_q;
	logic                  vld_q;
	logic                  adv;
	logic                  in_fire;
	cfg_t                  cfg;
	lvl_t [NUM_LEVELS-1:0] lvls;
	rsp_t                  res;
	upd_t                  upd;

	assign adv       = vld_s1 && (!vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;
	assign in_fire   = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1 <= req.data;
		end
		if (adv) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_q <= 1'b1;
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = vld_q;
	assign rsp.data  = rsp_q;

	dsak_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dsak_lvl_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.upd    (upd),
		.lvls   (lvls)
	);

	dsak_eval u_eval (
		.req  (req_s1),
		.cfg  (cfg),
		.lvls (lvls),
		.res  (res),
		.upd  (upd)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (rsp_q.accepted == (rsp_q.reject_code == RC_NONE)))
		else $error("accepted flag disagrees with reject code");

	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !rsp_q.accepted) |->
			(rsp_q.response_length == 4'd0 && rsp_q.seed_out == 64'd0 &&
			 rsp_q.echo_sub_fn == 8'd0))
		else $error("negative response carries payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.op) |=> (rsp_q.active_level == ACT_NONE && lvls == '0))
		else $error("reset op left a level open");

	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(lvls))
		else $error("level state changed without an item");

endmodule
`default_nettype wire

// ----- design/dsak_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dsak_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [dsak_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  wire logic [dsak_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	output dsak_pkg::cfg_t                          cfg
);
	import dsak_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit <= {RST_LIMIT, RST_LIMIT};
			cfg_q.delay <= {RST_DELAY, RST_DELAY};
			cfg_q.mask  <= {RST_MASK2, RST_MASK1};
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_L1_LIMIT: cfg_q.limit[0] <= cfg_wdata[7:0];
				CFG_L2_LIMIT: cfg_q.limit[1] <= cfg_wdata[7:0];
				CFG_L1_DELAY: cfg_q.delay[0] <= cfg_wdata[31:0];
				CFG_L2_DELAY: cfg_q.delay[1] <= cfg_wdata[31:0];
				CFG_L1_MASK:  cfg_q.mask[0]  <= cfg_wdata[2:0];
				CFG_L2_MASK:  cfg_q.mask[1]  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- design/dsak_lvl_state.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dsak_lvl_state (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire dsak_pkg::upd_t                        upd,
	output dsak_pkg::lvl_t [dsak_pkg::NUM_LEVELS-1:0] lvls
);
	import dsak_pkg::*;

	lvl_t [NUM_LEVELS-1:0] lvls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvls_q <= '0;
		end else if (en) begin
			if (upd.clr) begin
				lvls_q <= '0;
			end else if (upd.we) begin
				lvls_q[upd.idx] <= upd.lvl;
			end
		end
	end

	assign lvls = lvls_q;

endmodule
`default_nettype wire

// ----- design/dsak_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dsak_eval (
	input  wire dsak_pkg::req_t                        req,
	input  wire dsak_pkg::cfg_t                        cfg,
	input  wire dsak_pkg::lvl_t [dsak_pkg::NUM_LEVELS-1:0] lvls,
	output dsak_pkg::rsp_t                             res,
	output dsak_pkg::upd_t                             upd
);
	import dsak_pkg::*;

	logic                    lv;
	logic                    sf_ok;
	logic                    is_seed;
	logic [2:0]              cur_mask;
	lvl_t                    cur;
	lvl_t                    nl;
	logic [TIME_BITS-1:0]    t;
	logic [TIME_BITS-1:0]    elapsed;
	logic [31:0]             t32;
	logic [63:0]             new_seed;
	logic                    key_ok;
	logic [ATTEMPT_BITS-1:0] cnt_inc;
	logic [3:0]              seed_len;
	logic [7:0]              key_len;
	lvl_t [NUM_LEVELS-1:0]   post;

	always_comb begin
		lv       = (req.sub_fn == SF_L2_SEED) || (req.sub_fn == SF_L2_KEY);
		sf_ok    = req.sub_fn inside {SF_L1_SEED, SF_L1_KEY, SF_L2_SEED, SF_L2_KEY};
		is_seed  = (req.sub_fn == SF_L1_SEED) || (req.sub_fn == SF_L2_SEED);
		cur      = lvls[lv];
		t        = req.now_ms[TIME_BITS-1:0];
		t32      = 32'(t);
		elapsed  = t - cur.lstart;
		new_seed = lv ? {t32 ^ SEED2_HI_XOR, {t32[15:0], 16'h0000} ^ SEED2_LO_XOR}
		              : {32'h0, t32 ^ SEED1_XOR};
		key_ok   = lv ? (req.key_value == (cur.seed ^ KEY2_XOR))
		              : (req.key_value[31:0] == (cur.seed[31:0] ^ KEY1_XOR));
		cnt_inc  = (cur.fcount == CNT_MAX) ? cur.fcount : cur.fcount + 1'b1;
		seed_len = lv ? RSP_LEN_SEED2 : RSP_LEN_SEED1;
		key_len  = lv ? REQ_LEN_KEY2 : REQ_LEN_KEY1;

		case (req.session_id)
			SESS_PROG: cur_mask = MASK_PROG;
			SESS_EXT:  cur_mask = MASK_EXT;
			default:   cur_mask = MASK_DEFAULT;
		endcase

		res = '0;
		res.reject_code = RC_NONE;
		nl  = cur;
		upd.clr = 1'b0;
		upd.we  = 1'b0;
		upd.idx = lv;

		if (req.op) begin
			upd.clr = 1'b1;
			res.accepted = 1'b1;
		end else if (req.request_length < REQ_LEN_MIN) begin
			res.reject_code = RC_LENGTH;
		end else if (!sf_ok) begin
			res.reject_code = RC_UNSUPPORTED;
		end else if ((cfg.mask[lv] & cur_mask) == 3'b000) begin
			res.reject_code = RC_CONDITIONS;
		end else if (is_seed) begin
			if (cur.status == ST_UNLOCKED) begin
				res.accepted        = 1'b1;
				res.echo_sub_fn     = req.sub_fn;
				res.response_length = seed_len;
			end else if ((8'(cur.fcount) >= cfg.limit[lv]) &&
			             (32'(elapsed) < cfg.delay[lv])) begin
				res.reject_code = RC_DELAY;
			end else begin
				if (8'(cur.fcount) >= cfg.limit[lv]) begin
					nl.fcount = '0;
					upd.we    = 1'b1;
				end
				if (req.request_length != REQ_LEN_SEED) begin
					res.reject_code = RC_LENGTH;
				end else begin
					nl.seed             = new_seed;
					nl.status           = ST_SEEDED;
					upd.we              = 1'b1;
					res.accepted        = 1'b1;
					res.echo_sub_fn     = req.sub_fn;
					res.response_length = seed_len;
					res.seed_out        = new_seed;
				end
			end
		end else begin
			if (cur.status == ST_UNLOCKED) begin
				res.accepted        = 1'b1;
				res.echo_sub_fn     = req.sub_fn;
				res.response_length = RSP_LEN_KEY;
			end else if (cur.status != ST_SEEDED) begin
				res.reject_code = RC_SEQUENCE;
			end else if (req.request_length != key_len) begin
				res.reject_code = RC_LENGTH;
			end else if (key_ok) begin
				nl.status           = ST_UNLOCKED;
				nl.fcount           = '0;
				upd.we              = 1'b1;
				res.accepted        = 1'b1;
				res.echo_sub_fn     = req.sub_fn;
				res.response_length = RSP_LEN_KEY;
			end else begin
				nl.fcount = cnt_inc;
				nl.status = ST_LOCKED;
				upd.we    = 1'b1;
				if (8'(cnt_inc) >= cfg.limit[lv]) begin
					nl.lstart       = t;
					res.reject_code = RC_ATTEMPTS;
				end else begin
					res.reject_code = RC_BAD_KEY;
				end
			end
		end

		upd.lvl = nl;

		post = lvls;
		if (upd.clr) begin
			post = '0;
		end else if (upd.we) begin
			post[lv] = nl;
		end

		if (post[1].status == ST_UNLOCKED) begin
			res.active_level = ACT_L2;
		end else if (post[0].status == ST_UNLOCKED) begin
			res.active_level = ACT_L1;
		end else begin
			res.active_level = ACT_NONE;
		end
	end

endmodule
`default_nettype wire

// ----- test/tb_diag_security_access_seed_key_unit.sv -----
`timescale 1ns / 1ps
module tb_diag_security_access_seed_key_unit;
	import dsak_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_PHASE = 105;
	localparam int NUM_PHASES = 6;

	typedef struct {
		req_t r;
		bit   fixed;
		rsp_t want;
	} vec_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	dsak_req_if req_ch ();
	dsak_rsp_if rsp_ch ();

	diag_security_access_seed_key_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of registers and per-level state
	logic [7:0]           cfg_limit [2];
	logic [31:0]          cfg_delay [2];
	logic [2:0]           cfg_mask  [2];
	lvl_state_t           lvl_status [2];
	logic [ATTEMPT_BITS-1:0] fail_cnt [2];
	logic [TIME_BITS-1:0] lock_t0 [2];
	logic [63:0]          seed_reg [2];

	rsp_t pending_rsp [$];
	vec_t dir_tab [$];
	logic [31:0] now_ctr;
	int  cycles;
	int  n_sent;
	int  n_checked;
	int  n_errs;
	int  outcome_cnt [8];
	bit  src_quiet;
	bit  snk_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses pending", cycles, pending_rsp.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic void wipe_levels();
		for (int i = 0; i < NUM_LEVELS; i++) begin
			lvl_status[i] = ST_LOCKED;
			fail_cnt[i] = '0;
			lock_t0[i] = '0;
			seed_reg[i] = '0;
		end
	endfunction

	function automatic rsp_t access_step(req_t r);
		rsp_t o;
		int lv;
		bit want_seed;
		bit delay_hit;
		logic [2:0] sess_bit;
		logic [31:0] t;
		logic [TIME_BITS-1:0] elapsed;
		logic [63:0] want_key;
		logic [63:0] got_key;
		o = '0;
		o.reject_code = RC_NONE;
		t = 32'(r.now_ms[TIME_BITS-1:0]);
		if (r.op) begin
			wipe_levels();
			o.accepted = 1'b1;
		end else if (r.request_length < REQ_LEN_MIN) begin
			o.reject_code = RC_LENGTH;
		end else if (!(r.sub_fn inside {SF_L1_SEED, SF_L1_KEY, SF_L2_SEED, SF_L2_KEY})) begin
			o.reject_code = RC_UNSUPPORTED;
		end else begin
			lv = (r.sub_fn == SF_L2_SEED || r.sub_fn == SF_L2_KEY) ? 1 : 0;
			want_seed = (r.sub_fn == SF_L1_SEED || r.sub_fn == SF_L2_SEED);
			sess_bit = (r.session_id == SESS_PROG) ? MASK_PROG :
				(r.session_id == SESS_EXT) ? MASK_EXT : MASK_DEFAULT;
			if ((cfg_mask[lv] & sess_bit) == 3'b000) begin
				o.reject_code = RC_CONDITIONS;
			end else if (want_seed) begin
				if (lvl_status[lv] == ST_UNLOCKED) begin
					o.accepted = 1'b1;
					o.echo_sub_fn = r.sub_fn;
					o.response_length = lv ? RSP_LEN_SEED2 : RSP_LEN_SEED1;
				end else begin
					delay_hit = 1'b0;
					if (fail_cnt[lv] >= cfg_limit[lv]) begin
						elapsed = t[TIME_BITS-1:0] - lock_t0[lv];
						if (32'(elapsed) < cfg_delay[lv])
							delay_hit = 1'b1;
						else
							fail_cnt[lv] = '0;
					end
					if (delay_hit) begin
						o.reject_code = RC_DELAY;
					end else if (r.request_length != REQ_LEN_SEED) begin
						o.reject_code = RC_LENGTH;
					end else begin
						seed_reg[lv] = lv ? {t ^ SEED2_HI_XOR, (t << 16) ^ SEED2_LO_XOR}
							: {32'h0, t ^ SEED1_XOR};
						lvl_status[lv] = ST_SEEDED;
						o.accepted = 1'b1;
						o.echo_sub_fn = r.sub_fn;
						o.response_length = lv ? RSP_LEN_SEED2 : RSP_LEN_SEED1;
						o.seed_out = seed_reg[lv];
					end
				end
			end else begin
				if (lvl_status[lv] == ST_UNLOCKED) begin
					o.accepted = 1'b1;
					o.echo_sub_fn = r.sub_fn;
					o.response_length = RSP_LEN_KEY;
				end else if (lvl_status[lv] != ST_SEEDED) begin
					o.reject_code = RC_SEQUENCE;
				end else if (r.request_length != (lv ? REQ_LEN_KEY2 : REQ_LEN_KEY1)) begin
					o.reject_code = RC_LENGTH;
				end else begin
					want_key = lv ? (seed_reg[1] ^ KEY2_XOR)
						: {32'h0, seed_reg[0][31:0] ^ KEY1_XOR};
					got_key = lv ? r.key_value : {32'h0, r.key_value[31:0]};
					if (got_key == want_key) begin
						lvl_status[lv] = ST_UNLOCKED;
						fail_cnt[lv] = '0;
						o.accepted = 1'b1;
						o.echo_sub_fn = r.sub_fn;
						o.response_length = RSP_LEN_KEY;
					end else begin
						if (fail_cnt[lv] < CNT_MAX)
							fail_cnt[lv]++;
						lvl_status[lv] = ST_LOCKED;
						if (fail_cnt[lv] >= cfg_limit[lv]) begin
							lock_t0[lv] = t[TIME_BITS-1:0];
							o.reject_code = RC_ATTEMPTS;
						end else begin
							o.reject_code = RC_BAD_KEY;
						end
					end
				end
			end
		end
		o.active_level = (lvl_status[1] == ST_UNLOCKED) ? ACT_L2 :
			(lvl_status[0] == ST_UNLOCKED) ? ACT_L1 : ACT_NONE;
		return o;
	endfunction

	function automatic req_t mk_req(logic op, logic [7:0] sf, logic [7:0] len,
		logic [63:0] key, logic [7:0] sess, logic [31:0] now);
		req_t r;
		r.op = op;
		r.sub_fn = sf;
		r.request_length = len;
		r.key_value = key;
		r.session_id = sess;
		r.now_ms = now;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(logic acc, rej_code_t rc, logic [7:0] echo,
		logic [3:0] len, logic [63:0] seed, logic [1:0] lvl);
		rsp_t o;
		o.accepted = acc;
		o.reject_code = rc;
		o.echo_sub_fn = echo;
		o.response_length = len;
		o.seed_out = seed;
		o.active_level = lvl;
		return o;
	endfunction

	function automatic void add_row(req_t r, bit fixed, rsp_t want);
		vec_t v;
		v.r = r;
		v.fixed = fixed;
		v.want = want;
		dir_tab.push_back(v);
	endfunction

	function automatic logic [7:0] pick_sess(logic [2:0] m);
		int b;
		if (m == 3'b000 || $urandom_range(0, 15) == 0)
			return 8'($urandom);
		do b = $urandom_range(0, 2); while (!m[b]);
		case (b)
			0: return $urandom_range(0, 1) ? 8'd1 : 8'($urandom);
			1: return SESS_PROG;
			default: return SESS_EXT;
		endcase
	endfunction

	function automatic logic [31:0] step_clock();
		if ($urandom_range(0, 39) == 0)
			now_ctr = $urandom;
		else if ($urandom_range(0, 3) == 0)
			now_ctr += $urandom_range(0, 20000);
		else
			now_ctr += $urandom_range(0, 50);
		return now_ctr;
	endfunction

	function automatic req_t next_req();
		req_t r;
		int pick;
		int lv;
		logic [63:0] good;
		pick = $urandom_range(0, 99);
		lv = $urandom_range(0, 1);
		r.op = 1'b0;
		r.key_value = {$urandom, $urandom};
		r.now_ms = step_clock();
		r.session_id = pick_sess(cfg_mask[lv]);
		if (pick < 8) begin
			r.op = 1'b1;
			r.sub_fn = 8'($urandom);
			r.request_length = 8'($urandom);
		end else if (pick < 42) begin
			r.sub_fn = lv ? SF_L2_SEED : SF_L1_SEED;
			r.request_length = REQ_LEN_SEED;
		end else if (pick < 78) begin
			r.sub_fn = lv ? SF_L2_KEY : SF_L1_KEY;
			r.request_length = lv ? REQ_LEN_KEY2 : REQ_LEN_KEY1;
			good = lv ? (seed_reg[1] ^ KEY2_XOR)
				: {r.key_value[63:32], seed_reg[0][31:0] ^ KEY1_XOR};
			if ($urandom_range(0, 1))
				r.key_value = good;
			else if ($urandom_range(0, 1))
				r.key_value = good ^ (64'd1 << $urandom_range(0, lv ? 63 : 31));
		end else begin
			r.sub_fn = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
			r.request_length = $urandom_range(0, 2) == 0 ? 8'($urandom)
				: 8'($urandom_range(0, 11));
			r.session_id = 8'($urandom);
		end
		return r;
	endfunction

	task automatic push_req(req_t r, bit fixed, rsp_t want);
		int gap;
		rsp_t e;
		if ($urandom_range(0, 39) == 0)
			src_quiet = !src_quiet;
		gap = src_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		e = access_step(r);
		if (fixed)
			e = want;
		pending_rsp.push_back(e);
		outcome_cnt[e.reject_code]++;
		n_sent++;
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			CFG_L1_LIMIT: cfg_limit[0] = v[7:0];
			CFG_L2_LIMIT: cfg_limit[1] = v[7:0];
			CFG_L1_DELAY: cfg_delay[0] = v;
			CFG_L2_DELAY: cfg_delay[1] = v;
			CFG_L1_MASK:  cfg_mask[0] = v[2:0];
			CFG_L2_MASK:  cfg_mask[1] = v[2:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(logic [7:0] lim1, logic [7:0] lim2, logic [31:0] d1,
		logic [31:0] d2, logic [2:0] m1, logic [2:0] m2);
		write_reg(CFG_L1_LIMIT, 32'(lim1));
		write_reg(CFG_L2_LIMIT, 32'(lim2));
		write_reg(CFG_L1_DELAY, d1);
		write_reg(CFG_L2_DELAY, d2);
		write_reg(CFG_L1_MASK, 32'(m1));
		write_reg(CFG_L2_MASK, 32'(m2));
		cfg_we <= 1'b0;
	endtask

	// response side
	initial begin
		int gap;
		rsp_t want;
		rsp_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				snk_quiet = !snk_quiet;
			gap = snk_quiet ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				n_errs++;
				if (n_errs <= 10)
					$display("%0t: response with nothing pending: acc=%0b rc=%0d", $realtime,
						got.accepted, got.reject_code);
			end else begin
				want = pending_rsp.pop_front();
				n_checked++;
				if (got.accepted !== want.accepted || got.reject_code !== want.reject_code ||
					got.echo_sub_fn !== want.echo_sub_fn ||
					got.response_length !== want.response_length ||
					got.seed_out !== want.seed_out || got.active_level !== want.active_level) begin
					n_errs++;
					if (n_errs <= 10)
						$display({"%0t: response %0d mismatch\n",
							"  exp acc=%0b rc=%0d echo=%h len=%0d seed=%h lvl=%0d\n",
							"  got acc=%0b rc=%0d echo=%h len=%0d seed=%h lvl=%0d"},
							$realtime, n_checked,
							want.accepted, want.reject_code, want.echo_sub_fn,
							want.response_length, want.seed_out, want.active_level,
							got.accepted, got.reject_code, got.echo_sub_fn,
							got.response_length, got.seed_out, got.active_level);
				end
			end
		end
	end

	// request side and sequencing
	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		cycles = 0;
		now_ctr = $urandom;
		cfg_limit = '{RST_LIMIT, RST_LIMIT};
		cfg_delay = '{RST_DELAY, RST_DELAY};
		cfg_mask = '{RST_MASK1, RST_MASK2};
		wipe_levels();

		add_row(mk_req(1'b1, 8'hFF, 8'hFF, '1, 8'hFF, '1), 1'b1,
			mk_rsp(1'b1, RC_NONE, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_SEED, 8'd0, '0, SESS_PROG, '0), 1'b1,
			mk_rsp(1'b0, RC_LENGTH, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_SEED, 8'd1, '0, SESS_PROG, '0), 1'b1,
			mk_rsp(1'b0, RC_LENGTH, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, 8'h00, REQ_LEN_SEED, '0, SESS_PROG, '0), 1'b1,
			mk_rsp(1'b0, RC_UNSUPPORTED, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, 8'hFF, 8'hFF, '1, SESS_PROG, '1), 1'b1,
			mk_rsp(1'b0, RC_UNSUPPORTED, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, 8'd1, '0), 1'b1,
			mk_rsp(1'b0, RC_CONDITIONS, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L2_SEED, REQ_LEN_SEED, '0, SESS_EXT, '0), 1'b1,
			mk_rsp(1'b0, RC_CONDITIONS, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_KEY, REQ_LEN_KEY1, '0, SESS_EXT, '0), 1'b1,
			mk_rsp(1'b0, RC_SEQUENCE, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_SEED, 8'd3, '0, SESS_PROG, '0), 1'b1,
			mk_rsp(1'b0, RC_LENGTH, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_PROG, '0), 1'b1,
			mk_rsp(1'b1, RC_NONE, SF_L1_SEED, RSP_LEN_SEED1, {32'h0, SEED1_XOR}, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_KEY, REQ_LEN_KEY1, '0, SESS_PROG, '0), 1'b1,
			mk_rsp(1'b0, RC_BAD_KEY, 8'h0, 4'd0, 64'h0, ACT_NONE));
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_EXT, '1), 1'b0, '0);
		// upper key word must be ignored for level one
		add_row(mk_req(1'b0, SF_L1_KEY, REQ_LEN_KEY1,
			{32'hFFFFFFFF, ~SEED1_XOR ^ KEY1_XOR}, SESS_EXT, '0), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_PROG, 32'd5), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_KEY, REQ_LEN_KEY1, '0, SESS_PROG, 32'd5), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L2_SEED, REQ_LEN_SEED, '0, SESS_PROG, 32'h0000FFFF), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L2_KEY, REQ_LEN_KEY2,
			{32'h0000FFFF ^ SEED2_HI_XOR, 32'hFFFF0000 ^ SEED2_LO_XOR} ^ KEY2_XOR,
			SESS_PROG, 32'd1), 1'b0, '0);
		add_row(mk_req(1'b1, 8'h00, 8'h00, '0, 8'h00, '0), 1'b1,
			mk_rsp(1'b1, RC_NONE, 8'h0, 4'd0, 64'h0, ACT_NONE));
		// three bad keys reach the limit, then wait out the lockout window
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_EXT, 32'd100), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_KEY, REQ_LEN_KEY1, '1, SESS_EXT, 32'd150), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_EXT, 32'd200), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_KEY, REQ_LEN_KEY1, '1, SESS_EXT, 32'd250), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_EXT, 32'd300), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_KEY, REQ_LEN_KEY1, '1, SESS_EXT, 32'd1000), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_EXT, 32'd10999), 1'b0, '0);
		// window expired: count clears although the length is wrong
		add_row(mk_req(1'b0, SF_L1_SEED, 8'd3, '0, SESS_EXT, 32'd11000), 1'b0, '0);
		add_row(mk_req(1'b0, SF_L1_SEED, REQ_LEN_SEED, '0, SESS_EXT, 32'd11001), 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			push_req(dir_tab[i].r, dir_tab[i].fixed, dir_tab[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: program_regs(8'd1, 8'd1, 32'd0, 32'd0, 3'd7, 3'd7);
					2: program_regs(8'd255, 8'd2, '1, '1, MASK_DEFAULT, MASK_EXT);
					3: begin
						now_ctr = 32'hFFFFFF00;
						program_regs(8'd0, 8'd0, 32'd5, 32'd3, 3'd0, 3'd7);
					end
					default: program_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
						$urandom_range(0, 30000), $urandom_range(0, 30000),
						3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)));
				endcase
			end
			repeat (RAND_PER_PHASE) push_req(next_req(), 1'b0, '0);
		end

		settle();
		repeat (8) @(posedge clk);
		n_errs += pending_rsp.size();
		$display("Ran %0d requests across %0d register settings; %0d responses checked.",
			n_sent, NUM_PHASES, n_checked);
		$display({"Outcomes: ok %0d, length %0d, unsupported %0d, conditions %0d, delay %0d, ",
			"sequence %0d, bad key %0d, attempts %0d"},
			outcome_cnt[RC_NONE], outcome_cnt[RC_LENGTH], outcome_cnt[RC_UNSUPPORTED],
			outcome_cnt[RC_CONDITIONS], outcome_cnt[RC_DELAY], outcome_cnt[RC_SEQUENCE],
			outcome_cnt[RC_BAD_KEY], outcome_cnt[RC_ATTEMPTS]);
		if (n_errs == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors", n_errs);
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/dsak_pkg.sv
design/dsak_if.sv
design/dsak_cfg_regs.sv
design/dsak_lvl_state.sv
design/dsak_eval.sv
design/diag_security_access_seed_key_unit.sv
test/tb_diag_security_access_seed_key_unit.sv
